>>> src/slt_pkg.sv
// Shared types, constants and tables for the sinc lowpass tap generator.
`timescale 1ns / 1ps
`default_nettype none
package slt_pkg;

  localparam int unsigned TAP_W     = 9;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned CUTOFF_W  = 16;
  localparam int unsigned SIDE_W    = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MAG_W     = 9;
  localparam int unsigned CVAL_W    = 15;
  localparam int unsigned XY_W      = 34;
  localparam int unsigned Z_W       = 33;
  localparam int unsigned SMAG_W    = 31;
  localparam int unsigned NUM_W     = 62;
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned REM_W     = 8;

  localparam int unsigned MAX_SIDE_TAPS_DEF = 128;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_BEFORE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_AFTER  = 2'd2;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 16'd8192;
  localparam logic [SIDE_W-1:0]   SIDE_RST   = 8'd16;

  // CORDIC gain-compensated start, Q4.30
  localparam logic signed [XY_W-1:0] CORDIC_START_X = 34'sd652032874;
  // round(2^32 / pi)
  localparam logic [SMAG_W-1:0] INV_PI_Q32 = 31'd1367130551;

  // atan(2^-i) in turns scaled by 2^32
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Per-item sideband carried alongside the datapath
  typedef struct packed {
    logic              ok;
    logic              centre;
    logic [CVAL_W-1:0] cval;
    logic [MAG_W-1:0]  mag;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
    side_t                  side;
  } cordic_t;

  typedef struct packed {
    logic [DIV_W-1:0] dvd;
    logic [DIV_W-1:0] quo;
    logic [REM_W-1:0] rem;
    logic             neg;
    side_t            side;
  } div_t;

endpackage
`default_nettype wire

>>> src/slt_tap_if.sv
// Input stream channel carrying one tap offset per beat.
`timescale 1ns / 1ps
`default_nettype none
interface slt_tap_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [slt_pkg::TAP_W-1:0]       tap_offset;

  modport source (output valid, output tap_offset, input ready);
  modport sink   (input valid, input tap_offset, output ready);
endinterface
`default_nettype wire

>>> src/slt_coef_if.sv
// Output stream channel carrying one coefficient per beat.
`timescale 1ns / 1ps
`default_nettype none
interface slt_coef_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [slt_pkg::COEF_W-1:0]      coefficient;
  logic                                   in_range;

  modport source (output valid, output coefficient, output in_range, input ready);
  modport sink   (input valid, input coefficient, input in_range, output ready);
endinterface
`default_nettype wire

>>> src/sinc_lowpass_tap_generator_core.sv
// Top level: windowless sinc lowpass coefficient generator pipeline.
// Usage: push signed tap offsets n on tap_i; each beat yields one beat on
// coef_o carrying sin(2*pi*b*n)/(pi*n) as Q1.15 plus an in_range flag.
// The centre tap gives 2b (the cutoff register, saturated to 32767); an
// offset outside taps_before/taps_after gives zero with in_range low.
// Registers (cutoff, taps_before, taps_after) take cfg_idx_i / cfg_data_i on
// cfg_we_i; the user writes only while the pipeline is empty (unenforced).
// Throughput: one offset per cycle while coef_o is not held off. Stages in
// order: input stage, one register per CORDIC iteration, quadrant
// fold, 1/pi multiply, rounding, 16 restoring-division cells, output stage.
// The pipeline is a single stalled chain: when coef_o is held off with a
// beat waiting, every stage freezes and tap_i.ready drops until it moves.
// Reset empties the pipeline and loads cutoff 8192 and 16 taps each side.
`timescale 1ns / 1ps
`default_nettype none
module sinc_lowpass_tap_generator_core #(
  parameter int unsigned MAX_SIDE_TAPS = slt_pkg::MAX_SIDE_TAPS_DEF,
  parameter int unsigned CORDIC_STAGES = slt_pkg::CORDIC_STAGES_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [slt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [slt_pkg::CFG_W-1:0]         cfg_data_i,
  slt_tap_if.sink                          tap_i,
  slt_coef_if.source                       coef_o
);
  import slt_pkg::*;

  localparam int unsigned CMP_W = 11;

  // Configuration registers
  logic [CUTOFF_W-1:0] cutoff_q;
  logic [SIDE_W-1:0]   before_q, after_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RST;
      before_q <= SIDE_RST;
      after_q  <= SIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CUTOFF:      cutoff_q <= cfg_data_i;
        CFG_TAPS_BEFORE: before_q <= cfg_data_i[SIDE_W-1:0];
        CFG_TAPS_AFTER:  after_q  <= cfg_data_i[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en          = !out_vld_q || coef_o.ready;
  assign tap_i.ready = en;

  // Input stage: magnitude, window test, phase
  logic [MAG_W-1:0]    mag;
  logic                neg_n, ok;
  logic [CMP_W-1:0]    lim;
  logic [CUTOFF_W+MAG_W-1:0] phase_full;
  logic                in_vld_q;
  side_t               in_side_q;
  logic [CUTOFF_W-1:0] in_p_q;

  always_comb begin
    neg_n = tap_i.tap_offset[TAP_W-1];
    mag   = neg_n ? MAG_W'(-tap_i.tap_offset) : MAG_W'(tap_i.tap_offset);
    lim   = neg_n ? CMP_W'(before_q) : CMP_W'(after_q);
    ok    = (CMP_W'(mag) <= lim) && (CMP_W'(mag) <= CMP_W'(MAX_SIDE_TAPS));
    phase_full = cutoff_q * mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= tap_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_side_q.ok     <= ok;
      in_side_q.centre <= (mag == '0);
      in_side_q.cval   <= cutoff_q[CUTOFF_W-1] ? '1 : cutoff_q[CVAL_W-1:0];
      in_side_q.mag    <= mag;
      in_p_q           <= phase_full[CUTOFF_W-1:0];
    end
  end

  // CORDIC chain
  cordic_t cd [CORDIC_STAGES+1];
  logic    cv [CORDIC_STAGES+1];

  assign cv[0]      = in_vld_q;
  assign cd[0].x    = CORDIC_START_X;
  assign cd[0].y    = '0;
  assign cd[0].z    = $signed({3'b000, in_p_q[13:0], 16'd0});
  assign cd[0].quad = in_p_q[15:14];
  assign cd[0].side = in_side_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    slt_cordic_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (cv[g]),
      .dat_i  (cd[g]),
      .vld_o  (cv[g+1]),
      .dat_o  (cd[g+1])
    );
  end

  // Quadrant fold and clamp
  cordic_t                cl;
  logic signed [XY_W-1:0] s;
  logic signed [XY_W-1:0] s_c;
  logic                   fold_vld_q;
  logic [SMAG_W-1:0]      fold_mag_q;
  logic                   fold_neg_q;
  side_t                  fold_side_q;

  always_comb begin
    cl = cd[CORDIC_STAGES];
    case (cl.quad)
      2'd0:    s = cl.y;
      2'd1:    s = cl.x;
      2'd2:    s = -cl.y;
      default: s = -cl.x;
    endcase
    s_c = s;
    if (s > $signed(XY_W'(1) <<< 30))  s_c = $signed(XY_W'(1) <<< 30);
    if (s < -$signed(XY_W'(1) <<< 30)) s_c = -$signed(XY_W'(1) <<< 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
    end else if (en) begin
      fold_vld_q <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fold_neg_q  <= s_c[XY_W-1];
      fold_mag_q  <= s_c[XY_W-1] ? SMAG_W'(-s_c) : SMAG_W'(s_c);
      fold_side_q <= cl.side;
    end
  end

  // Scale by 1/pi
  logic             mul_vld_q;
  logic [NUM_W-1:0] mul_num_q;
  logic             mul_neg_q;
  side_t            mul_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (en) begin
      mul_vld_q <= fold_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_num_q  <= fold_mag_q * INV_PI_Q32;
      mul_neg_q  <= fold_neg_q;
      mul_side_q <= fold_side_q;
    end
  end

  // Round-half-up bias and drop of the 2^47 scale
  logic [NUM_W:0] biased;
  logic           rnd_vld_q;
  div_t           rnd_q;

  assign biased = {1'b0, mul_num_q} + ((NUM_W+1)'(mul_side_q.mag) << 46);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_vld_q <= 1'b0;
    end else if (en) begin
      rnd_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rnd_q.dvd  <= biased[NUM_W:NUM_W-DIV_W+1];
      rnd_q.quo  <= '0;
      rnd_q.rem  <= '0;
      rnd_q.neg  <= mul_neg_q;
      rnd_q.side <= mul_side_q;
    end
  end

  // Division by |n|, one quotient bit per cell
  div_t dd [DIV_W+1];
  logic dv [DIV_W+1];

  assign dd[0] = rnd_q;
  assign dv[0] = rnd_vld_q;

  for (genvar g = 0; g < DIV_W; g++) begin : g_div
    slt_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv[g]),
      .dat_i  (dd[g]),
      .vld_o  (dv[g+1]),
      .dat_o  (dd[g+1])
    );
  end

  // Sign, saturation, special cases, output register
  div_t                     dl;
  logic signed [COEF_W-1:0] coef_d;
  logic signed [COEF_W-1:0] coef_q;
  logic                     rng_q;

  always_comb begin
    dl = dd[DIV_W];
    if (!dl.side.ok) begin
      coef_d = '0;
    end else if (dl.side.centre) begin
      coef_d = $signed({1'b0, dl.side.cval});
    end else if (dl.neg) begin
      coef_d = (dl.quo > DIV_W'(32768)) ? $signed(16'h8000) : $signed(-dl.quo);
    end else begin
      coef_d = (dl.quo > DIV_W'(32767)) ? $signed(16'h7fff) : $signed(dl.quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv[DIV_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      coef_q <= coef_d;
      rng_q  <= dl.side.ok;
    end
  end

  assign coef_o.valid       = out_vld_q;
  assign coef_o.coefficient = coef_q;
  assign coef_o.in_range    = rng_q;
endmodule
`default_nettype wire

>>> src/slt_cordic_cell.sv
// One rotation-mode CORDIC iteration with its pipeline register.
`timescale 1ns / 1ps
`default_nettype none
module slt_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  vld_i,
  input  slt_pkg::cordic_t     dat_i,
  output logic                 vld_o,
  output slt_pkg::cordic_t     dat_o
);
  import slt_pkg::*;

  logic                   vld_q;
  cordic_t                dat_q, dat_d;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  atn;

  // Micro-rotation towards zero residual angle
  always_comb begin
    dx  = dat_i.y >>> IDX;
    dy  = dat_i.x >>> IDX;
    atn = $signed({1'b0, ATAN_TURNS[IDX]});
    dat_d = dat_i;
    if (!dat_i.z[Z_W-1]) begin
      dat_d.x = dat_i.x - dx;
      dat_d.y = dat_i.y + dy;
      dat_d.z = dat_i.z - atn;
    end else begin
      dat_d.x = dat_i.x + dx;
      dat_d.y = dat_i.y - dy;
      dat_d.z = dat_i.z + atn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;
endmodule
`default_nettype wire

>>> src/slt_div_cell.sv
// One restoring-division step: a quotient bit per cell.
`timescale 1ns / 1ps
`default_nettype none
module slt_div_cell (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              en_i,
  input  wire              vld_i,
  input  slt_pkg::div_t    dat_i,
  output logic             vld_o,
  output slt_pkg::div_t    dat_o
);
  import slt_pkg::*;

  logic             vld_q;
  div_t             dat_q, dat_d;
  logic [REM_W:0]   trial;
  logic             take;

  // Shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    trial = {dat_i.rem, dat_i.dvd[DIV_W-1]};
    take  = (trial >= dat_i.side.mag);
    dat_d = dat_i;
    dat_d.dvd = {dat_i.dvd[DIV_W-2:0], 1'b0};
    dat_d.quo = {dat_i.quo[DIV_W-2:0], take};
    dat_d.rem = take ? REM_W'(trial - dat_i.side.mag) : trial[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;
endmodule
`default_nettype wire
